@@ rtl/core/lidar_scan_to_pixel_projection_macros.svh @@
// ----------------------------------------------------------------------------
// Lidar scan to pixel projection - assertion macros
// Concurrent check helpers, compiled away for synthesis.
// ----------------------------------------------------------------------------
`ifndef LIDAR_SCAN_TO_PIXEL_PROJECTION_MACROS_SVH
`define LIDAR_SCAN_TO_PIXEL_PROJECTION_MACROS_SVH
`ifndef SYNTHESIS
// cons must hold whenever ante holds
`define LSP_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lidar projection check failed");
// cond must never be true
`define LSP_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("lidar projection check failed");
`else
`define LSP_ASSERT_IMPL(label, clk, rst, ante, cons)
`define LSP_ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

@@ rtl/core/lsp_pkg.sv @@
// ----------------------------------------------------------------------------
// lsp_pkg
// Shared constants, types and tables of the lidar projection pipeline.
// ----------------------------------------------------------------------------
package lsp_pkg;

   // CORDIC datapath
   localparam int CORDIC_STAGES   = 16;
   localparam int CW              = 20;   // x / y width, signed
   localparam int ZW              = 34;   // angle accumulator width, signed
   localparam int CORDIC_GAIN_INV = 39797;

   localparam logic [31:0] ATAN_TURNS [24] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   localparam logic signed [ZW-1:0] QUARTER_TURN = 34'sd1073741824;
   localparam logic signed [ZW-1:0] HALF_TURN    = 34'sd2147483648;

   // divider datapath
   localparam int QW = 11;                // quotient bits
   localparam int DW = 27;                // dividend bits
   localparam int MW = 16;                // divisor bits

   // image limits
   localparam logic [10:0] MAX_IMAGE_SIDE = 11'd1024;
   localparam logic [9:0]  PIX_FIELD_MAX  = 10'd1023;

   // register indexes
   typedef enum logic [2:0] {
      CSR_MIN_RANGE   = 3'd0,
      CSR_MAX_RANGE   = 3'd1,
      CSR_START_ANGLE = 3'd2,
      CSR_ANGLE_STEP  = 3'd3,
      CSR_HEADING     = 3'd4,
      CSR_IMAGE_SIZE  = 3'd5
   } csr_index_type;

   // sideband through the CORDIC
   typedef struct packed {
      logic [15:0] range;
      logic        rej;
      logic        flip;
   } cordic_side_type;

   // sideband through the divider
   typedef struct packed {
      logic rej;
      logic neg_x;
      logic neg_y;
   } div_side_type;

endpackage

@@ rtl/core/lsp_cordic.sv @@
// ----------------------------------------------------------------------------
// lsp_cordic
// Pipelined rotation-mode CORDIC, one micro-rotation per register stage.
// ----------------------------------------------------------------------------
`include "lidar_scan_to_pixel_projection_macros.svh"

module lsp_cordic (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [lsp_pkg::ZW-1:0] in_z,
   input  lsp_pkg::cordic_side_type      in_side,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic signed [lsp_pkg::CW-1:0] out_x,
   output logic signed [lsp_pkg::CW-1:0] out_y,
   output lsp_pkg::cordic_side_type      out_side
);
   import lsp_pkg::*;

   logic                  vld_ff  [CORDIC_STAGES];
   logic signed [CW-1:0]  x_ff    [CORDIC_STAGES];
   logic signed [CW-1:0]  y_ff    [CORDIC_STAGES];
   logic signed [ZW-1:0]  z_ff    [CORDIC_STAGES];
   cordic_side_type       side_ff [CORDIC_STAGES];

   logic                  src_v   [CORDIC_STAGES];
   logic signed [CW-1:0]  src_x   [CORDIC_STAGES];
   logic signed [CW-1:0]  src_y   [CORDIC_STAGES];
   logic signed [ZW-1:0]  src_z   [CORDIC_STAGES];
   cordic_side_type       src_s   [CORDIC_STAGES];
   logic signed [CW-1:0]  x_in    [CORDIC_STAGES];
   logic signed [CW-1:0]  y_in    [CORDIC_STAGES];
   logic signed [ZW-1:0]  z_in    [CORDIC_STAGES];
   logic [CORDIC_STAGES:0] rdy;

   localparam logic signed [ZW-1:0] Z_LIMIT = QUARTER_TURN;

   assign rdy[CORDIC_STAGES] = out_ready;
   assign in_ready           = rdy[0];

   // stage sources and micro-rotations
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
      localparam logic signed [ZW-1:0] ATAN_I =
         $signed({{(ZW-32){1'b0}}, ATAN_TURNS[i]});

      if (i == 0) begin : g_first
         assign src_v[i] = in_valid;
         assign src_x[i] = CW'(CORDIC_GAIN_INV);
         assign src_y[i] = '0;
         assign src_z[i] = in_z;
         assign src_s[i] = in_side;
      end else begin : g_next
         assign src_v[i] = vld_ff[i-1];
         assign src_x[i] = x_ff[i-1];
         assign src_y[i] = y_ff[i-1];
         assign src_z[i] = z_ff[i-1];
         assign src_s[i] = side_ff[i-1];
      end

      always_comb begin
         if (src_z[i] >= 0) begin
            x_in[i] = src_x[i] - (src_y[i] >>> i);
            y_in[i] = src_y[i] + (src_x[i] >>> i);
            z_in[i] = src_z[i] - ATAN_I;
         end else begin
            x_in[i] = src_x[i] + (src_y[i] >>> i);
            y_in[i] = src_y[i] - (src_x[i] >>> i);
            z_in[i] = src_z[i] + ATAN_I;
         end
      end

      assign rdy[i] = !vld_ff[i] || rdy[i+1];
   end

   // stage valid bits
   always_ff @(posedge clock) begin
      for (int i = 0; i < CORDIC_STAGES; i++) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (rdy[i]) begin
            vld_ff[i] <= src_v[i];
         end
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      for (int i = 0; i < CORDIC_STAGES; i++) begin
         if (rdy[i] && src_v[i]) begin
            x_ff[i]    <= x_in[i];
            y_ff[i]    <= y_in[i];
            z_ff[i]    <= z_in[i];
            side_ff[i] <= src_s[i];
         end
      end
   end

   assign out_valid = vld_ff[CORDIC_STAGES-1];
   assign out_x     = x_ff[CORDIC_STAGES-1];
   assign out_y     = y_ff[CORDIC_STAGES-1];
   assign out_side  = side_ff[CORDIC_STAGES-1];

   // folded angle must stay within a quarter turn
   `LSP_ASSERT_NEVER(a_z_folded, clock, reset,
      in_valid && (in_z > Z_LIMIT || in_z < -Z_LIMIT))

endmodule

@@ rtl/core/lsp_div.sv @@
// ----------------------------------------------------------------------------
// lsp_div
// Two-lane pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`include "lidar_scan_to_pixel_projection_macros.svh"

module lsp_div (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [lsp_pkg::MW-1:0] divisor,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [lsp_pkg::DW-1:0] in_num_x,
   input  logic [lsp_pkg::DW-1:0] in_num_y,
   input  lsp_pkg::div_side_type  in_side,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [lsp_pkg::QW-1:0] out_q_x,
   output logic [lsp_pkg::QW-1:0] out_q_y,
   output lsp_pkg::div_side_type  out_side
);
   import lsp_pkg::*;

   logic              vld_ff  [QW];
   logic [DW-1:0]     rx_ff   [QW];
   logic [DW-1:0]     ry_ff   [QW];
   logic [QW-1:0]     qx_ff   [QW];
   logic [QW-1:0]     qy_ff   [QW];
   div_side_type      side_ff [QW];

   logic              src_v   [QW];
   logic [DW-1:0]     src_rx  [QW];
   logic [DW-1:0]     src_ry  [QW];
   logic [QW-1:0]     src_qx  [QW];
   logic [QW-1:0]     src_qy  [QW];
   div_side_type      src_s   [QW];
   logic [DW-1:0]     rx_in   [QW];
   logic [DW-1:0]     ry_in   [QW];
   logic [QW-1:0]     qx_in   [QW];
   logic [QW-1:0]     qy_in   [QW];
   logic [QW:0]       rdy;

   assign rdy[QW]  = out_ready;
   assign in_ready = rdy[0];

   // one trial subtraction per stage, most significant quotient bit first
   for (genvar i = 0; i < QW; i++) begin : g_stage
      localparam int B = QW - 1 - i;
      logic [DW-1:0] trial;

      if (i == 0) begin : g_first
         assign src_v[i]  = in_valid;
         assign src_rx[i] = in_num_x;
         assign src_ry[i] = in_num_y;
         assign src_qx[i] = '0;
         assign src_qy[i] = '0;
         assign src_s[i]  = in_side;
      end else begin : g_next
         assign src_v[i]  = vld_ff[i-1];
         assign src_rx[i] = rx_ff[i-1];
         assign src_ry[i] = ry_ff[i-1];
         assign src_qx[i] = qx_ff[i-1];
         assign src_qy[i] = qy_ff[i-1];
         assign src_s[i]  = side_ff[i-1];
      end

      assign trial = DW'(divisor) << B;

      always_comb begin
         qx_in[i] = src_qx[i];
         qy_in[i] = src_qy[i];
         if (src_rx[i] >= trial) begin
            rx_in[i]    = src_rx[i] - trial;
            qx_in[i][B] = 1'b1;
         end else begin
            rx_in[i]    = src_rx[i];
         end
         if (src_ry[i] >= trial) begin
            ry_in[i]    = src_ry[i] - trial;
            qy_in[i][B] = 1'b1;
         end else begin
            ry_in[i]    = src_ry[i];
         end
      end

      assign rdy[i] = !vld_ff[i] || rdy[i+1];
   end

   // stage valid bits
   always_ff @(posedge clock) begin
      for (int i = 0; i < QW; i++) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (rdy[i]) begin
            vld_ff[i] <= src_v[i];
         end
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      for (int i = 0; i < QW; i++) begin
         if (rdy[i] && src_v[i]) begin
            rx_ff[i]   <= rx_in[i];
            ry_ff[i]   <= ry_in[i];
            qx_ff[i]   <= qx_in[i];
            qy_ff[i]   <= qy_in[i];
            side_ff[i] <= src_s[i];
         end
      end
   end

   assign out_valid = vld_ff[QW-1];
   assign out_q_x   = qx_ff[QW-1];
   assign out_q_y   = qy_ff[QW-1];
   assign out_side  = side_ff[QW-1];

   // kept returns must leave a proper remainder (quotient did not overflow)
   `LSP_ASSERT_IMPL(a_rem_bound, clock, reset,
      out_valid && !out_side.rej,
      rx_ff[QW-1] < DW'(divisor) && ry_ff[QW-1] < DW'(divisor))

endmodule

@@ rtl/core/lidar_scan_to_pixel_projection.sv @@
// ----------------------------------------------------------------------------
// lidar_scan_to_pixel_projection
// Projects one lidar return (range, ray index) to a pixel of a square image.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one return per transaction (range_mm, ray_index).
//   rsp_ channel carries one result per transaction (pixel_x, pixel_y,
//   hit_valid), in input order. Returns out of range give zeros, flag low.
//   csr_ port writes one register per cycle while csr_we is high; write
//   only while no transaction is in flight.
// Timing:
//   Between req acceptance and rsp_valid lie two angle stages, 16 CORDIC
//   stages, two multiply stages, 11 divider stages (one quotient bit each)
//   and the output register. One transaction per cycle while rsp_ready is high.
// Reset:
//   clears all pipeline valid bits and loads the register defaults.
// Stall:
//   each stage holds when the next one is full and stalled; bubbles are
//   squeezed out, so input is still taken until the whole pipe is full.
// ----------------------------------------------------------------------------
`include "lidar_scan_to_pixel_projection_macros.svh"

module lidar_scan_to_pixel_projection (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_range_mm,
   input  logic [11:0] req_ray_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [9:0]  rsp_pixel_x,
   output logic [9:0]  rsp_pixel_y,
   output logic        rsp_hit_valid,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import lsp_pkg::*;

   // configuration registers
   logic [15:0] min_range_ff, max_range_ff, start_angle_ff, angle_step_ff, heading_ff;
   logic [10:0] image_size_ff;
   logic [10:0] size_sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_range_ff   <= 16'd120;
         max_range_ff   <= 16'd3500;
         start_angle_ff <= 16'd0;
         angle_step_ff  <= 16'd182;
         heading_ff     <= 16'd0;
         image_size_ff  <= 11'd410;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MIN_RANGE:   min_range_ff   <= csr_wdata;
            CSR_MAX_RANGE:   max_range_ff   <= csr_wdata;
            CSR_START_ANGLE: start_angle_ff <= csr_wdata;
            CSR_ANGLE_STEP:  angle_step_ff  <= csr_wdata;
            CSR_HEADING:     heading_ff     <= csr_wdata;
            CSR_IMAGE_SIZE:  image_size_ff  <= csr_wdata[10:0];
            default: ;
         endcase
      end
   end

   assign size_sat = (image_size_ff > MAX_IMAGE_SIDE) ? MAX_IMAGE_SIDE : image_size_ff;

   // ready chain
   logic s0_rdy, s1_rdy, s2_rdy, s3_rdy, out_rdy;
   logic cor_in_rdy, div_in_rdy;
   logic cor_vld, div_vld;

   // stage 0: range check, ray angle product
   logic        s0_vld_ff, s0_rej_ff;
   logic [15:0] s0_range_ff, s0_prod_ff;
   logic        s0_rej_in;
   logic [27:0] s0_prod_full;

   assign s0_rdy       = !s0_vld_ff || s1_rdy;
   assign req_ready    = s0_rdy;
   assign s0_rej_in    = !(req_range_mm > min_range_ff && req_range_mm < max_range_ff);
   assign s0_prod_full = {16'd0, req_ray_index} * {12'd0, angle_step_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else if (s0_rdy) begin
         s0_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_rdy && req_valid) begin
         s0_range_ff <= req_range_mm;
         s0_rej_ff   <= s0_rej_in;
         s0_prod_ff  <= s0_prod_full[15:0];
      end
   end

   // stage 1: beam angle and quadrant fold
   logic                 s1_vld_ff;
   logic signed [ZW-1:0] s1_z_ff, s1_z_in, s1_zr;
   cordic_side_type      s1_side_ff;
   logic                 s1_flip_in;
   logic [15:0]          s1_bam;

   assign s1_rdy = !s1_vld_ff || cor_in_rdy;
   assign s1_bam = start_angle_ff + s0_prod_ff + heading_ff;
   assign s1_zr  = $signed({{2{s1_bam[15]}}, s1_bam, 16'd0});

   always_comb begin
      s1_z_in    = s1_zr;
      s1_flip_in = 1'b0;
      if (s1_zr > QUARTER_TURN) begin
         s1_z_in    = s1_zr - HALF_TURN;
         s1_flip_in = 1'b1;
      end else if (s1_zr < -QUARTER_TURN) begin
         s1_z_in    = s1_zr + HALF_TURN;
         s1_flip_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (s1_rdy) begin
         s1_vld_ff <= s0_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_rdy && s0_vld_ff) begin
         s1_z_ff          <= s1_z_in;
         s1_side_ff.range <= s0_range_ff;
         s1_side_ff.rej   <= s0_rej_ff;
         s1_side_ff.flip  <= s1_flip_in;
      end
   end

   // CORDIC
   logic signed [CW-1:0] cor_x, cor_y;
   cordic_side_type      cor_side;

   lsp_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_vld_ff),
      .in_ready  (cor_in_rdy),
      .in_z      (s1_z_ff),
      .in_side   (s1_side_ff),
      .out_valid (cor_vld),
      .out_ready (s2_rdy),
      .out_x     (cor_x),
      .out_y     (cor_y),
      .out_side  (cor_side)
   );

   // stage 2: sign / magnitude of trig, times range
   logic                 s2_vld_ff, s2_rej_ff, s2_neg_x_ff, s2_neg_y_ff;
   logic [32:0]          s2_px_ff, s2_py_ff;
   logic signed [CW-1:0] s2_ax, s2_ay;
   logic                 s2_neg_x_in, s2_neg_y_in;

   assign s2_rdy      = !s2_vld_ff || s3_rdy;
   assign s2_ax       = cor_x[CW-1] ? -cor_x : cor_x;
   assign s2_ay       = cor_y[CW-1] ? -cor_y : cor_y;
   assign s2_neg_x_in = cor_side.flip ? (cor_x > 0) : cor_x[CW-1];
   assign s2_neg_y_in = cor_side.flip ? (cor_y > 0) : cor_y[CW-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (s2_rdy) begin
         s2_vld_ff <= cor_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_rdy && cor_vld) begin
         s2_px_ff    <= {17'd0, cor_side.range} * {16'd0, s2_ax[16:0]};
         s2_py_ff    <= {17'd0, cor_side.range} * {16'd0, s2_ay[16:0]};
         s2_rej_ff   <= cor_side.rej;
         s2_neg_x_ff <= s2_neg_x_in;
         s2_neg_y_ff <= s2_neg_y_in;
      end
   end

   // stage 3: times image size
   logic         s3_vld_ff;
   logic [43:0]  s3_px_ff, s3_py_ff;
   div_side_type s3_side_ff;

   assign s3_rdy = !s3_vld_ff || div_in_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (s3_rdy) begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_rdy && s2_vld_ff) begin
         s3_px_ff         <= {11'd0, s2_px_ff} * {33'd0, size_sat};
         s3_py_ff         <= {11'd0, s2_py_ff} * {33'd0, size_sat};
         s3_side_ff.rej   <= s2_rej_ff;
         s3_side_ff.neg_x <= s2_neg_x_ff;
         s3_side_ff.neg_y <= s2_neg_y_ff;
      end
   end

   // divide by max range; the 2 * 65536 factor is the dropped low 17 bits
   logic [QW-1:0] div_qx, div_qy;
   div_side_type  div_side;

   lsp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .divisor   (max_range_ff),
      .in_valid  (s3_vld_ff),
      .in_ready  (div_in_rdy),
      .in_num_x  (s3_px_ff[43:17]),
      .in_num_y  (s3_py_ff[43:17]),
      .in_side   (s3_side_ff),
      .out_valid (div_vld),
      .out_ready (out_rdy),
      .out_q_x   (div_qx),
      .out_q_y   (div_qy),
      .out_side  (div_side)
   );

   // output stage: sign, center offset, bounds and clip
   logic               rsp_vld_ff, rsp_hit_ff;
   logic [9:0]         rsp_x_ff, rsp_y_ff;
   logic signed [12:0] qx_s, qy_s, half_s, px, py;
   logic [9:0]         px_clip, py_clip;
   logic               in_image;

   assign out_rdy  = !rsp_vld_ff || rsp_ready;
   assign half_s   = $signed({3'd0, size_sat[10:1]});
   assign qx_s     = div_side.neg_x ? -$signed({2'd0, div_qx}) : $signed({2'd0, div_qx});
   assign qy_s     = div_side.neg_y ? -$signed({2'd0, div_qy}) : $signed({2'd0, div_qy});
   assign px       = qx_s + half_s;
   assign py       = qy_s + half_s;
   assign in_image = !px[12] && !py[12] &&
                     (px[11:0] < {1'b0, size_sat}) && (py[11:0] < {1'b0, size_sat});

   always_comb begin
      if (px[12]) begin
         px_clip = '0;
      end else if (px[11:0] > {2'd0, PIX_FIELD_MAX}) begin
         px_clip = PIX_FIELD_MAX;
      end else begin
         px_clip = px[9:0];
      end
      if (py[12]) begin
         py_clip = '0;
      end else if (py[11:0] > {2'd0, PIX_FIELD_MAX}) begin
         py_clip = PIX_FIELD_MAX;
      end else begin
         py_clip = py[9:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (out_rdy) begin
         rsp_vld_ff <= div_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (out_rdy && div_vld) begin
         rsp_x_ff   <= div_side.rej ? 10'd0 : px_clip;
         rsp_y_ff   <= div_side.rej ? 10'd0 : py_clip;
         rsp_hit_ff <= !div_side.rej && in_image;
      end
   end

   assign rsp_valid     = rsp_vld_ff;
   assign rsp_pixel_x   = rsp_x_ff;
   assign rsp_pixel_y   = rsp_y_ff;
   assign rsp_hit_valid = rsp_hit_ff;

   // a reported hit lies inside the image
   `LSP_ASSERT_IMPL(a_hit_inside, clock, reset,
      rsp_valid && rsp_hit_valid,
      (({1'b0, rsp_pixel_x} < size_sat) && ({1'b0, rsp_pixel_y} < size_sat)))

endmodule
